// ----- src/cdmp_pkg.sv -----
// Shared types, codes and helpers of the command-driven motor PWM block.
package cdmp_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned HEAD_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [OP_W-1:0]      op_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [HEAD_W-1:0]    head_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam op_t OP_CMD  = 2'd0;
  localparam op_t OP_PWM  = 2'd1;
  localparam op_t OP_RAMP = 2'd2;

  localparam mode_t MODE_STOP  = 2'd0;
  localparam mode_t MODE_ACCEL = 2'd1;
  localparam mode_t MODE_DECEL = 2'd2;

  localparam head_t HEAD_NONE  = 3'd0;
  localparam head_t HEAD_FWD   = 3'd1;
  localparam head_t HEAD_REV   = 3'd2;
  localparam head_t HEAD_LEFT  = 3'd3;
  localparam head_t HEAD_RIGHT = 3'd4;

  localparam byte_t CMD_FWD   = 8'h71;
  localparam byte_t CMD_UP    = 8'h77;
  localparam byte_t CMD_DOWN  = 8'h65;
  localparam byte_t CMD_STOP  = 8'h72;
  localparam byte_t CMD_REV   = 8'h74;
  localparam byte_t CMD_LEFT  = 8'h79;
  localparam byte_t CMD_RIGHT = 8'h75;

  localparam byte_t PAT_NONE  = 8'h00;
  localparam byte_t PAT_FWD   = 8'h11;
  localparam byte_t PAT_REV   = 8'h33;
  localparam byte_t PAT_LEFT  = 8'h31;
  localparam byte_t PAT_RIGHT = 8'h13;

  localparam level_t LEVEL_MIN = 3'd1;
  localparam level_t LEVEL_MAX = 3'd5;

  localparam cfg_idx_t CFG_PWM_FLOOR  = 2'd0;
  localparam cfg_idx_t CFG_PWM_TOP    = 2'd1;
  localparam cfg_idx_t CFG_START_DUTY = 2'd2;
  localparam cfg_idx_t CFG_DUTY_STEP  = 2'd3;

  localparam byte_t RST_PWM_FLOOR  = 8'd20;
  localparam byte_t RST_PWM_TOP    = 8'd200;
  localparam byte_t RST_START_DUTY = 8'd70;
  localparam byte_t RST_DUTY_STEP  = 8'd20;

  function automatic byte_t pattern_for(input head_t head);
    byte_t pat;
    case (head)
      HEAD_FWD:   pat = PAT_FWD;
      HEAD_REV:   pat = PAT_REV;
      HEAD_LEFT:  pat = PAT_LEFT;
      HEAD_RIGHT: pat = PAT_RIGHT;
      default:    pat = PAT_NONE;
    endcase
    return pat;
  endfunction

endpackage

// ----- src/cdmp_if.sv -----
// Valid/ready channel interfaces for requests and results of the motor PWM block.
interface cdmp_in_if;
  import cdmp_pkg::*;

  logic  valid;
  logic  ready;
  op_t   op;
  byte_t command_byte;

  modport source (output valid, output op, output command_byte, input ready);
  modport sink (input valid, input op, input command_byte, output ready);
endinterface

interface cdmp_out_if;
  import cdmp_pkg::*;

  logic   valid;
  logic   ready;
  byte_t  drive_pattern;
  byte_t  duty_level;
  level_t level_now;
  mode_t  mode_now;
  head_t  heading;

  modport source (output valid, output drive_pattern, output duty_level, output level_now,
                  output mode_now, output heading, input ready);
  modport sink (input valid, input drive_pattern, input duty_level, input level_now,
                input mode_now, input heading, output ready);
endinterface

// ----- src/command_driven_motor_pwm.sv -----
// Top level of the command-driven two-motor PWM bridge controller.
//
// Requests arrive on in_req: op selects a command byte, a PWM tick or a ramp
// tick. Each accepted request yields exactly one result on out_rsp, holding
// the bridge pattern, ramped duty, speed level, run mode and heading after
// the request has been applied. Configuration registers (PWM floor, PWM top,
// start duty, duty step) are written through cfg_we, cfg_idx and cfg_data, by
// the user only while the block is idle; the block itself has no check on it.
//
// A request is captured in an input register; then the state update is done
// in one pass and the result is loaded into the output register. One request
// per cycle is sustained while the receiver keeps ready high. The output
// register and the input register form two stages, so a request is still
// taken while a result waits.
// When the receiver holds ready low, the result is held and at most one more
// request is buffered before in_req.ready drops.
// Reset (rst_n low, synchronous) restores all state and register defaults
// and empties both stages.
module command_driven_motor_pwm (
  input  logic                     clk,
  input  logic                     rst_n,
  cdmp_in_if.sink                  in_req,
  cdmp_out_if.source               out_rsp,
  input  logic                     cfg_we,
  input  cdmp_pkg::cfg_idx_t       cfg_idx,
  input  cdmp_pkg::byte_t          cfg_data
);
  import cdmp_pkg::*;

  byte_t  pwm_floor_r, pwm_top_r, start_duty_r, duty_step_r;

  logic   s1_valid_r;
  op_t    s1_op_r;
  byte_t  s1_cmd_r;

  mode_t  run_mode_r, run_mode_nxt;
  head_t  direction_r, direction_nxt;
  level_t speed_level_r, speed_level_nxt;
  logic   started_r, started_nxt;
  byte_t  duty_r, duty_nxt;
  byte_t  duty_target_r, duty_target_nxt;
  byte_t  pwm_count_r, pwm_count_nxt;
  byte_t  pattern_r, pattern_nxt;

  logic   out_valid_r;
  byte_t  out_pattern_r, out_duty_r;
  level_t out_level_r;
  mode_t  out_mode_r;
  head_t  out_head_r;

  logic   out_load;
  logic   s1_adv;
  logic [BYTE_W:0] sum_w;
  logic [BYTE_W:0] cnt_inc;

  assign out_load = !out_valid_r || out_rsp.ready;
  assign s1_adv   = s1_valid_r && out_load;
  assign in_req.ready = !s1_valid_r || out_load;

  always_comb begin
    run_mode_nxt    = run_mode_r;
    direction_nxt   = direction_r;
    speed_level_nxt = speed_level_r;
    started_nxt     = started_r;
    duty_nxt        = duty_r;
    duty_target_nxt = duty_target_r;
    pwm_count_nxt   = pwm_count_r;
    pattern_nxt     = pattern_r;
    sum_w   = {1'b0, duty_target_r} + {1'b0, duty_step_r};
    cnt_inc = {1'b0, pwm_count_r} + {{BYTE_W{1'b0}}, 1'b1};
    case (s1_op_r)
      OP_CMD: begin
        case (s1_cmd_r)
          CMD_FWD, CMD_REV, CMD_LEFT, CMD_RIGHT: begin
            run_mode_nxt    = MODE_ACCEL;
            duty_target_nxt = start_duty_r;
            started_nxt     = 1'b1;
            if (speed_level_r < 3'd2) begin
              case (s1_cmd_r)
                CMD_FWD:  direction_nxt = HEAD_FWD;
                CMD_REV:  direction_nxt = HEAD_REV;
                CMD_LEFT: direction_nxt = HEAD_LEFT;
                default:  direction_nxt = HEAD_RIGHT;
              endcase
            end
          end
          CMD_UP: begin
            if (started_r && speed_level_r < LEVEL_MAX) begin
              run_mode_nxt    = MODE_ACCEL;
              duty_target_nxt = sum_w[BYTE_W] ? {BYTE_W{1'b1}} : sum_w[BYTE_W-1:0];
              speed_level_nxt = speed_level_r + 3'd1;
            end
          end
          CMD_DOWN: begin
            if (speed_level_r > LEVEL_MIN) begin
              run_mode_nxt    = MODE_DECEL;
              duty_target_nxt = (duty_target_r > duty_step_r) ?
                                duty_target_r - duty_step_r : '0;
              speed_level_nxt = speed_level_r - 3'd1;
            end
          end
          CMD_STOP: begin
            run_mode_nxt    = MODE_STOP;
            speed_level_nxt = LEVEL_MIN;
            duty_nxt        = '0;
            direction_nxt   = HEAD_NONE;
            started_nxt     = 1'b0;
            pattern_nxt     = PAT_NONE;
          end
          default: begin
          end
        endcase
      end
      OP_PWM: begin
        if (run_mode_r != MODE_STOP) begin
          pattern_nxt   = (pwm_count_r > duty_r) ? PAT_NONE : pattern_for(direction_r);
          pwm_count_nxt = (cnt_inc > {1'b0, pwm_top_r}) ? pwm_floor_r : cnt_inc[BYTE_W-1:0];
        end
      end
      OP_RAMP: begin
        if (run_mode_r != MODE_STOP) begin
          if (duty_r < duty_target_r) begin
            duty_nxt = duty_r + 8'd1;
          end else if (duty_r > duty_target_r) begin
            duty_nxt = duty_r - 8'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_floor_r  <= RST_PWM_FLOOR;
      pwm_top_r    <= RST_PWM_TOP;
      start_duty_r <= RST_START_DUTY;
      duty_step_r  <= RST_DUTY_STEP;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PWM_FLOOR:  pwm_floor_r  <= cfg_data;
        CFG_PWM_TOP:    pwm_top_r    <= cfg_data;
        CFG_START_DUTY: start_duty_r <= cfg_data;
        CFG_DUTY_STEP:  duty_step_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
    if (in_req.valid && in_req.ready) begin
      s1_op_r  <= in_req.op;
      s1_cmd_r <= in_req.command_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mode_r    <= MODE_STOP;
      direction_r   <= HEAD_NONE;
      speed_level_r <= LEVEL_MIN;
      started_r     <= 1'b0;
      duty_r        <= '0;
      duty_target_r <= RST_START_DUTY;
      pwm_count_r   <= RST_PWM_FLOOR;
      pattern_r     <= PAT_NONE;
    end else if (s1_adv) begin
      run_mode_r    <= run_mode_nxt;
      direction_r   <= direction_nxt;
      speed_level_r <= speed_level_nxt;
      started_r     <= started_nxt;
      duty_r        <= duty_nxt;
      duty_target_r <= duty_target_nxt;
      pwm_count_r   <= pwm_count_nxt;
      pattern_r     <= pattern_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_adv) begin
      out_pattern_r <= pattern_nxt;
      out_duty_r    <= duty_nxt;
      out_level_r   <= speed_level_nxt;
      out_mode_r    <= run_mode_nxt;
      out_head_r    <= direction_nxt;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.drive_pattern = out_pattern_r;
  assign out_rsp.duty_level    = out_duty_r;
  assign out_rsp.level_now     = out_level_r;
  assign out_rsp.mode_now      = out_mode_r;
  assign out_rsp.heading       = out_head_r;

endmodule

// ----- src/cdmp_checker.sv -----
// Port-level assertion checker for the motor PWM block and its bind statement.
module cdmp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input cdmp_pkg::byte_t   drive_pattern,
  input cdmp_pkg::byte_t   duty_level,
  input cdmp_pkg::level_t  level_now,
  input cdmp_pkg::mode_t   mode_now,
  input cdmp_pkg::head_t   heading
);
  import cdmp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(drive_pattern) && $stable(duty_level) &&
      $stable(level_now) && $stable(mode_now) && $stable(heading))
    else $error("result changed while stalled");

  a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_now == MODE_STOP |-> drive_pattern == PAT_NONE &&
      duty_level == 8'd0 && level_now == LEVEL_MIN && heading == HEAD_NONE)
    else $error("stopped state shows drive activity");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> level_now >= LEVEL_MIN && level_now <= LEVEL_MAX)
    else $error("speed level out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind command_driven_motor_pwm cdmp_checker u_cdmp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .drive_pattern (out_rsp.drive_pattern),
  .duty_level    (out_rsp.duty_level),
  .level_now     (out_rsp.level_now),
  .mode_now      (out_rsp.mode_now),
  .heading       (out_rsp.heading)
);
